[rtl/qarc_pkg.sv]
// Shared widths, types, register codes and arithmetic helpers for the attitude controller.
`default_nettype none

package qarc_pkg;

   localparam int IN_DATA_W  = 176;
   localparam int OUT_DATA_W = 128;
   localparam int FLD_W      = 16;
   localparam int PROD_W     = 32;
   localparam int ERR_W      = 34;
   localparam int MAT_W      = 35;
   localparam int MUL_W      = 51;
   localparam int SUM_W      = 53;
   localparam int RATE_W     = 24;
   localparam int THR_W      = 18;
   localparam int GAIN_W     = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_ROLL_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_YAW_GAIN   = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

   localparam int RATE_SHIFT = 23;
   localparam int THR_SHIFT  = 28;

   typedef logic signed [FLD_W-1:0]  fld_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ERR_W-1:0]  err_type;
   typedef logic signed [MAT_W-1:0]  mat_type;
   typedef logic signed [MUL_W-1:0]  mul_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef struct packed {
      logic                   valid;
      logic [2:0][ERR_W-1:0]  e;
      logic [8:0][MAT_W-1:0]  r;
      logic [2:0][FLD_W-1:0]  t;
   } front_out_type;

   function automatic prod_type mul16(input fld_type a, input fld_type b);
      return PROD_W'(a) * PROD_W'(b);
   endfunction

   function automatic logic [RATE_W-1:0] sat_rate(input sum_type v);
      sum_type q;
      q = v >>> RATE_SHIFT;
      if (q > SUM_W'(signed'(24'sh7FFFFF))) begin
         return 24'h7FFFFF;
      end else if (q < SUM_W'(signed'(24'sh800000))) begin
         return 24'h800000;
      end
      return q[RATE_W-1:0];
   endfunction

   function automatic logic [THR_W-1:0] sat_thr(input sum_type v);
      sum_type q;
      q = v >>> THR_SHIFT;
      if (q > SUM_W'(signed'(18'sh1FFFF))) begin
         return 18'h1FFFF;
      end else if (q < SUM_W'(signed'(18'sh20000))) begin
         return 18'h20000;
      end
      return q[THR_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/qarc_front.sv]
// Front pipeline: quaternion products, error vector and body rotation matrix.
`default_nettype none

module qarc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic [qarc_pkg::IN_DATA_W-1:0] in_data,
   output qarc_pkg::front_out_type            out_q
);
   import qarc_pkg::*;

   fld_type  m_w, m_x, m_y, m_z, d_w, d_x, d_y, d_z;
   prod_type s1_ep_in [12];
   prod_type s1_rp_in [9];
   prod_type s1_ep_ff [12];
   prod_type s1_rp_ff [9];
   fld_type  s1_t_ff  [3];
   logic     s1_valid_ff;

   err_type  s2_e_in  [3];
   mat_type  s2_r_in  [9];
   front_out_type s2_ff;

   always_comb begin
      m_w = fld_type'(in_data[0*FLD_W +: FLD_W]);
      m_x = fld_type'(in_data[1*FLD_W +: FLD_W]);
      m_y = fld_type'(in_data[2*FLD_W +: FLD_W]);
      m_z = fld_type'(in_data[3*FLD_W +: FLD_W]);
      d_w = fld_type'(in_data[4*FLD_W +: FLD_W]);
      d_x = fld_type'(in_data[5*FLD_W +: FLD_W]);
      d_y = fld_type'(in_data[6*FLD_W +: FLD_W]);
      d_z = fld_type'(in_data[7*FLD_W +: FLD_W]);
      s1_ep_in[0]  = mul16(m_w, d_x);
      s1_ep_in[1]  = mul16(d_w, m_x);
      s1_ep_in[2]  = mul16(m_y, d_z);
      s1_ep_in[3]  = mul16(m_z, d_y);
      s1_ep_in[4]  = mul16(m_w, d_y);
      s1_ep_in[5]  = mul16(d_w, m_y);
      s1_ep_in[6]  = mul16(m_z, d_x);
      s1_ep_in[7]  = mul16(m_x, d_z);
      s1_ep_in[8]  = mul16(m_w, d_z);
      s1_ep_in[9]  = mul16(d_w, m_z);
      s1_ep_in[10] = mul16(m_x, d_y);
      s1_ep_in[11] = mul16(m_y, d_x);
      s1_rp_in[0]  = mul16(m_x, m_x);
      s1_rp_in[1]  = mul16(m_y, m_y);
      s1_rp_in[2]  = mul16(m_z, m_z);
      s1_rp_in[3]  = mul16(m_x, m_y);
      s1_rp_in[4]  = mul16(m_x, m_z);
      s1_rp_in[5]  = mul16(m_y, m_z);
      s1_rp_in[6]  = mul16(m_w, m_x);
      s1_rp_in[7]  = mul16(m_w, m_y);
      s1_rp_in[8]  = mul16(m_w, m_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ep_ff <= s1_ep_in;
         s1_rp_ff <= s1_rp_in;
         for (int i = 0; i < 3; i++) begin
            s1_t_ff[i] <= fld_type'(in_data[(8+i)*FLD_W +: FLD_W]);
         end
      end
   end

   function automatic mat_type twice_sum(input prod_type a, input prod_type b, input logic neg);
      mat_type s;
      s = neg ? (MAT_W'(a) - MAT_W'(b)) : (MAT_W'(a) + MAT_W'(b));
      return s <<< 1;
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_e_in[i] = ERR_W'(s1_ep_ff[4*i]) - ERR_W'(s1_ep_ff[4*i+1])
                    - (ERR_W'(s1_ep_ff[4*i+2]) - ERR_W'(s1_ep_ff[4*i+3]));
      end
      // xx yy zz xy xz yz wx wy wz
      s2_r_in[0] = (MAT_W'(1) <<< THR_SHIFT) - twice_sum(s1_rp_ff[1], s1_rp_ff[2], 1'b0);
      s2_r_in[1] = twice_sum(s1_rp_ff[3], s1_rp_ff[8], 1'b0);
      s2_r_in[2] = twice_sum(s1_rp_ff[4], s1_rp_ff[7], 1'b1);
      s2_r_in[3] = twice_sum(s1_rp_ff[3], s1_rp_ff[8], 1'b1);
      s2_r_in[4] = (MAT_W'(1) <<< THR_SHIFT) - twice_sum(s1_rp_ff[0], s1_rp_ff[2], 1'b0);
      s2_r_in[5] = twice_sum(s1_rp_ff[5], s1_rp_ff[6], 1'b0);
      s2_r_in[6] = twice_sum(s1_rp_ff[4], s1_rp_ff[7], 1'b0);
      s2_r_in[7] = twice_sum(s1_rp_ff[5], s1_rp_ff[6], 1'b1);
      s2_r_in[8] = (MAT_W'(1) <<< THR_SHIFT) - twice_sum(s1_rp_ff[0], s1_rp_ff[1], 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_ff.valid <= s1_valid_ff;
      end
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            s2_ff.e[i] <= s2_e_in[i];
            s2_ff.t[i] <= s1_t_ff[i];
         end
         for (int i = 0; i < 9; i++) begin
            s2_ff.r[i] <= s2_r_in[i];
         end
      end
   end

   assign out_q = s2_ff;

endmodule

`default_nettype wire

[rtl/quaternion_attitude_rate_controller.sv]
// Top level: attitude error rate setpoints and body-frame thrust, five-stage pipeline.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata: 11 x 16b quaternions, thrust; tuser: flag
//  rsp     | out       | rsp_tvalid/tready    | tdata: 3 x 24b rates, 3 x 18b body thrust
//  csr     | in        | csr_we               | csr_index 2b, csr_wdata 16b
//
// One item per cycle while the pipeline is not held; rsp_tvalid is registered in the last stage.
// Stages: products, error/matrix sums, wide multiplies, sums with rounding bias, shift and clamp.
// Items with the setpoint flag low are dropped at the first stage.
// The whole pipeline holds while rsp_tvalid is high and rsp_tready is low.
// Synchronous reset clears all valid bits and loads the gains with 1.0.
`default_nettype none

module quaternion_attitude_rate_controller (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // meas_w, meas_x, meas_y, meas_z, want_w, want_x, want_y, want_z,
   // world_thrust_x, world_thrust_y, world_thrust_z
   input  wire logic [qarc_pkg::IN_DATA_W-1:0]    req_tdata,
   // setpoint_valid
   input  wire logic [0:0]                       req_tuser,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // roll_rate, pitch_rate, yaw_rate, body_thrust_x, body_thrust_y, body_thrust_z, 2 zero bits
   output      logic [qarc_pkg::OUT_DATA_W-1:0]   rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [qarc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [qarc_pkg::GAIN_W-1:0]       csr_wdata
);
   import qarc_pkg::*;

   logic [GAIN_W-1:0] roll_gain_ff, pitch_gain_ff, yaw_gain_ff;
   logic [GAIN_W-1:0] gain [3];
   logic              pipe_en;
   front_out_type     front_q;

   mul_type s3_rate_in [3];
   mul_type s3_thr_in  [9];
   mul_type s3_rate_ff [3];
   mul_type s3_thr_ff  [9];
   logic    s3_valid_ff;

   sum_type s4_rate_in [3];
   sum_type s4_thr_in  [3];
   sum_type s4_rate_ff [3];
   sum_type s4_thr_ff  [3];
   logic    s4_valid_ff;

   logic [OUT_DATA_W-1:0] rsp_tdata_in;
   logic [OUT_DATA_W-1:0] rsp_tdata_ff;
   logic                  rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_gain_ff  <= GAIN_RESET;
         pitch_gain_ff <= GAIN_RESET;
         yaw_gain_ff   <= GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_ROLL_GAIN:  roll_gain_ff  <= csr_wdata;
            REG_PITCH_GAIN: pitch_gain_ff <= csr_wdata;
            REG_YAW_GAIN:   yaw_gain_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign gain[0]    = roll_gain_ff;
   assign gain[1]    = pitch_gain_ff;
   assign gain[2]    = yaw_gain_ff;
   assign pipe_en    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = pipe_en;

   qarc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (pipe_en),
      .in_valid (req_tvalid && req_tuser[0]),
      .in_data  (req_tdata),
      .out_q    (front_q)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_rate_in[i] = MUL_W'(signed'({1'b0, gain[i]})) * MUL_W'(err_type'(front_q.e[i]));
         for (int j = 0; j < 3; j++) begin
            s3_thr_in[3*i+j] = MUL_W'(mat_type'(front_q.r[3*i+j]))
                             * MUL_W'(fld_type'(front_q.t[j]));
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_rate_in[i] = SUM_W'(s3_rate_ff[i]) + (SUM_W'(1) <<< (RATE_SHIFT - 1));
         s4_thr_in[i]  = SUM_W'(s3_thr_ff[3*i]) + SUM_W'(s3_thr_ff[3*i+1])
                       + SUM_W'(s3_thr_ff[3*i+2]) + (SUM_W'(1) <<< (THR_SHIFT - 1));
      end
      rsp_tdata_in = {2'b00,
                      sat_thr(s4_thr_ff[2]), sat_thr(s4_thr_ff[1]), sat_thr(s4_thr_ff[0]),
                      sat_rate(s4_rate_ff[2]), sat_rate(s4_rate_ff[1]),
                      sat_rate(s4_rate_ff[0])};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_valid_ff   <= front_q.valid;
         s4_valid_ff   <= s3_valid_ff;
         rsp_tvalid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_rate_ff   <= s3_rate_in;
         s3_thr_ff    <= s3_thr_in;
         s4_rate_ff   <= s4_rate_in;
         s4_thr_ff    <= s4_thr_in;
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_drop_empty: assert property (@(posedge clock) disable iff (reset)
      pipe_en && !front_q.valid |=> !s3_valid_ff)
      else $error("empty slot became valid");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(s3_valid_ff) && $stable(s4_valid_ff) && rsp_tvalid)
      else $error("pipeline moved during stall");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      pipe_en |=> rsp_tvalid == $past(s4_valid_ff))
      else $error("output valid lost its item");

   a_gain_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == REG_ROLL_GAIN |=> roll_gain_ff == $past(csr_wdata))
      else $error("roll gain write lost");

endmodule

`default_nettype wire

[bench/tb.sv]
// Testbench for the quaternion attitude rate controller: directed table, random items, gain phases.
`timescale 1ns / 100ps

module tb;
   import qarc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int     SETTLE_CYCLES   = 8;
   localparam int     ITEMS_PER_PHASE = 140;
   localparam int     CYCLE_LIMIT     = 400000;
   localparam int     SQUEEZE_CYCLES  = 150;
   localparam longint RATE_HI = 64'sd8388607;
   localparam longint RATE_LO = -64'sd8388608;
   localparam longint THR_HI  = 64'sd131071;
   localparam longint THR_LO  = -64'sd131072;

   typedef struct packed {
      logic [3:0][FLD_W-1:0] meas;
      logic [3:0][FLD_W-1:0] want;
      logic [2:0][FLD_W-1:0] thrust;
      logic                  flag;
   } sample_type;

   typedef struct packed {
      logic [2:0][RATE_W-1:0] rate;
      logic [2:0][THR_W-1:0]  thr;
   } attitude_cmd_type;

   typedef struct {
      sample_type       smp;
      bit               known;
      attitude_cmd_type cmd;
   } step_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata  = '0;
   logic [0:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [GAIN_W-1:0]     csr_wdata  = '0;

   logic [GAIN_W-1:0] gain_model [3];
   attitude_cmd_type  pending_cmds [$];
   step_row_type      step_rows [$];
   int                mismatches  = 0;
   int                rsp_count   = 0;
   int                cycle_count = 0;
   int                send_calm   = 0;
   string             field_names [6] = '{"roll_rate", "pitch_rate", "yaw_rate",
                                          "body_thrust_x", "body_thrust_y", "body_thrust_z"};

   quaternion_attitude_rate_controller uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("quaternion_attitude_rate_controller: mismatch");
         $finish;
      end
   end

   function automatic longint round_clamp(longint v, int s, longint lo, longint hi);
      longint q;
      q = (v + (longint'(1) <<< (s - 1))) >>> s;
      return (q < lo) ? lo : ((q > hi) ? hi : q);
   endfunction

   function automatic attitude_cmd_type predict_rate_cmd(sample_type s);
      longint           m [4];
      longint           d [4];
      longint           t [3];
      longint           e [3];
      longint           r [9];
      longint           one;
      attitude_cmd_type c;
      int               i;
      for (i = 0; i < 4; i++) begin
         m[i] = longint'($signed(s.meas[i]));
         d[i] = longint'($signed(s.want[i]));
      end
      for (i = 0; i < 3; i++) t[i] = longint'($signed(s.thrust[i]));
      e[0] = m[0] * d[1] - d[0] * m[1] - (m[2] * d[3] - m[3] * d[2]);
      e[1] = m[0] * d[2] - d[0] * m[2] - (m[3] * d[1] - m[1] * d[3]);
      e[2] = m[0] * d[3] - d[0] * m[3] - (m[1] * d[2] - m[2] * d[1]);
      one  = longint'(1) <<< 28;
      r[0] = one - 2 * (m[2] * m[2] + m[3] * m[3]);
      r[1] = 2 * (m[1] * m[2] + m[0] * m[3]);
      r[2] = 2 * (m[1] * m[3] - m[0] * m[2]);
      r[3] = 2 * (m[1] * m[2] - m[0] * m[3]);
      r[4] = one - 2 * (m[1] * m[1] + m[3] * m[3]);
      r[5] = 2 * (m[2] * m[3] + m[0] * m[1]);
      r[6] = 2 * (m[1] * m[3] + m[0] * m[2]);
      r[7] = 2 * (m[2] * m[3] - m[0] * m[1]);
      r[8] = one - 2 * (m[1] * m[1] + m[2] * m[2]);
      for (i = 0; i < 3; i++) begin
         c.rate[i] = RATE_W'(round_clamp(longint'(gain_model[i]) * e[i], RATE_SHIFT,
                                         RATE_LO, RATE_HI));
         c.thr[i]  = THR_W'(round_clamp(r[3*i] * t[0] + r[3*i+1] * t[1] + r[3*i+2] * t[2],
                                        THR_SHIFT, THR_LO, THR_HI));
      end
      return c;
   endfunction

   function automatic void add_row(int mw, int mx, int my, int mz, int dw, int dx, int dy,
                                   int dz, int tx, int ty, int tz, bit flag, bit known,
                                   int rr, int rp, int ry, int bx, int by, int bz);
      step_row_type row;
      row.smp.meas   = {16'(mz), 16'(my), 16'(mx), 16'(mw)};
      row.smp.want   = {16'(dz), 16'(dy), 16'(dx), 16'(dw)};
      row.smp.thrust = {16'(tz), 16'(ty), 16'(tx)};
      row.smp.flag   = flag;
      row.known      = known;
      row.cmd.rate   = {24'(ry), 24'(rp), 24'(rr)};
      row.cmd.thr    = {18'(bz), 18'(by), 18'(bx)};
      step_rows.push_back(row);
   endfunction

   function automatic int idle_len(bit allow_zero);
      int r;
      r = $urandom_range(0, 99);
      if (allow_zero && r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [FLD_W-1:0] rand_comp(int mode);
      if (mode < 7) return 16'($urandom_range(0, 32768) - 16384);
      if (mode < 9) return 16'($urandom);
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h4000;
         3: return 16'hC000;
         default: return 16'h0000;
      endcase
   endfunction

   function automatic sample_type rand_sample();
      sample_type s;
      int         mode;
      int         i;
      mode = $urandom_range(0, 9);
      for (i = 0; i < 4; i++) begin
         s.meas[i] = rand_comp(mode);
         s.want[i] = rand_comp(mode);
      end
      for (i = 0; i < 3; i++)
         s.thrust[i] = ($urandom_range(0, 9) == 0) ? rand_comp(9) : 16'($urandom);
      s.flag = ($urandom_range(0, 99) < 85);
      return s;
   endfunction

   task automatic send_sample(sample_type s, bit known, attitude_cmd_type cmd);
      int gap;
      if (send_calm > 0) begin
         send_calm--;
         gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
         send_calm = $urandom_range(10, 40);
         gap = 0;
      end else begin
         gap = idle_len(1'b1);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s.thrust, s.want, s.meas};
      req_tuser  <= s.flag;
      do @(posedge clock); while (!req_tready);
      if (s.flag) pending_cmds.push_back(known ? cmd : predict_rate_cmd(s));
   endtask

   task automatic send_random(int count);
      int k;
      for (k = 0; k < count; k++) send_sample(rand_sample(), 1'b0, '0);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gain(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_ROLL_GAIN:  gain_model[0] = value;
         REG_PITCH_GAIN: gain_model[1] = value;
         REG_YAW_GAIN:   gain_model[2] = value;
         default: ;
      endcase
   endtask

   task automatic apply_gains(logic [GAIN_W-1:0] roll, logic [GAIN_W-1:0] pitch,
                              logic [GAIN_W-1:0] yaw, bit touch_spare);
      write_gain(REG_ROLL_GAIN, roll);
      write_gain(REG_PITCH_GAIN, pitch);
      if (touch_spare) write_gain(REG_SPARE, 16'($urandom));
      write_gain(REG_YAW_GAIN, yaw);
      csr_we <= 1'b0;
   endtask

   task automatic check_result();
      attitude_cmd_type want;
      longint           ev;
      longint           av;
      int               i;
      rsp_count++;
      if (pending_cmds.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result item, tdata %h", rsp_tdata);
         return;
      end
      want = pending_cmds.pop_front();
      if ($isunknown(rsp_tdata[125:0])) begin
         mismatches++;
         if (mismatches <= 10) $display("unknown bits in result item, tdata %h", rsp_tdata);
         return;
      end
      for (i = 0; i < 6; i++) begin
         if (i < 3) begin
            ev = longint'($signed(want.rate[i]));
            av = longint'($signed(rsp_tdata[24*i +: 24]));
         end else begin
            ev = longint'($signed(want.thr[i-3]));
            av = longint'($signed(rsp_tdata[72+18*(i-3) +: 18]));
         end
         if (ev != av) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d %s: expected %0d, got %0d",
                        rsp_count, field_names[i], ev, av);
         end
      end
   endtask

   initial begin
      int hold_cnt;
      int calm_cnt;
      bit squeeze_done;
      hold_cnt     = 0;
      calm_cnt     = 0;
      squeeze_done = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) check_result();
         if (hold_cnt > 0) begin
            rsp_tready <= 1'b0;
            hold_cnt--;
         end else begin
            rsp_tready <= 1'b1;
            if (!squeeze_done && rsp_count >= 30) begin
               hold_cnt     = SQUEEZE_CYCLES;
               squeeze_done = 1'b1;
            end else if (calm_cnt > 0) begin
               calm_cnt--;
            end else if ($urandom_range(0, 19) == 0) begin
               calm_cnt = $urandom_range(10, 60);
            end else if ($urandom_range(0, 3) == 0) begin
               hold_cnt = idle_len(1'b0);
            end
         end
      end
   end

   initial begin
      int k;
      for (k = 0; k < 3; k++) gain_model[k] = GAIN_RESET;

      // identity attitude passes thrust straight through; a unit want about one axis gives a rate of +-8192
      add_row(16384, 0, 0, 0, 16384, 0, 0, 0, 1000, -2000, 3000, 1, 1, 0, 0, 0, 1000, -2000, 3000);
      add_row(16384, 0, 0, 0, 16384, 0, 0, 0, 1000, -2000, 3000, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(16384, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 1, 1, 8192, 0, 0, 0, 0, 0);
      add_row(16384, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 1, 1, 0, 8192, 0, 0, 0, 0);
      add_row(16384, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 1, 1, 0, 0, 8192, 0, 0, 0);
      add_row(16384, 0, 0, 0, 0, -16384, 0, 0, 0, 0, 0, 1, 1, -8192, 0, 0, 0, 0, 0);
      // negative scalar part of the error keeps its sign
      add_row(16384, 0, 0, 0, -16384, 0, 0, 0, 32767, 32767, 32767, 1, 1,
              0, 0, 0, 32767, 32767, 32767);
      add_row(16384, 0, 0, 0, -16384, 16384, 0, 0, 0, 0, 0, 1, 1, 8192, 0, 0, 0, 0, 0);
      add_row(16384, 0, 0, 0, 16384, 0, 0, 0, -32768, -32768, -32768, 1, 1,
              0, 0, 0, -32768, -32768, -32768);
      // half-way rounding goes up
      add_row(1, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0);
      add_row(1, 0, 0, 0, 0, -16384, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0);
      // thrust clamps at both ends
      add_row(0, -32768, 0, 0, 0, 0, 0, 0, 0, 32767, 0, 1, 1, 0, 0, 0, 0, -131072, 0);
      add_row(0, -32768, 0, 0, 0, 0, 0, 0, 0, -32768, 0, 1, 1, 0, 0, 0, 0, 131071, 0);
      add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
              -32768, -32768, -32768, 1, 0, 0, 0, 0, 0, 0, 0);
      add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
              32767, 32767, 32767, 1, 0, 0, 0, 0, 0, 0, 0);
      add_row(11585, 11585, 0, 0, 16384, 0, 0, 0, 0, 0, 16384, 1, 0, 0, 0, 0, 0, 0, 0);
      add_row(16384, 16384, 16384, 16384, -16384, 16384, -16384, 16384,
              32767, -32768, 32767, 1, 0, 0, 0, 0, 0, 0, 0);
      add_row(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768,
              -32768, 32767, -32768, 1, 0, 0, 0, 0, 0, 0, 0);
      add_row(16384, 0, 0, 0, 32767, -32768, 32767, -32768, 12345, -23456, 7, 1, 0,
              0, 0, 0, 0, 0, 0);
      add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
              32767, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (step_rows[k]) send_sample(step_rows[k].smp, step_rows[k].known, step_rows[k].cmd);
      send_random(ITEMS_PER_PHASE);
      drain();

      apply_gains(16'd0, 16'd0, 16'd0, 1'b1);
      send_random(ITEMS_PER_PHASE);
      drain();

      apply_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_random(ITEMS_PER_PHASE);
      drain();

      apply_gains(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
      send_random(ITEMS_PER_PHASE);
      drain();

      apply_gains(16'd1, 16'h8000, 16'd4096, 1'b0);
      send_random(ITEMS_PER_PHASE);
      drain();

      if (mismatches == 0) begin
         $display("quaternion_attitude_rate_controller: match");
      end else begin
         $display("quaternion_attitude_rate_controller: mismatch");
      end
      $finish;
   end

endmodule
